[src/occb_pkg.sv]
// Shared types and constants of the overlap cluster contig builder.
package occb_pkg;

   // Default values of the top level parameters.
   localparam int MAX_COUNT_DEF = 128 * 1024;
   localparam int POS_BITS_DEF  = 32;

   // Number of record slots that one input beat can fill.
   localparam int SLOTS = 4;

   // Record kinds.
   localparam logic [1:0] KIND_PLACEMENT = 2'd0;
   localparam logic [1:0] KIND_CONTIG    = 2'd1;
   localparam logic [1:0] KIND_PAIR      = 2'd2;
   localparam logic [1:0] KIND_SCAFFOLD  = 2'd3;

   // Slot positions, in output order.
   localparam int SLOT_CONTIG    = 0;
   localparam int SLOT_PAIR      = 1;
   localparam int SLOT_SCAFFOLD  = 2;
   localparam int SLOT_PLACEMENT = 3;

   // One alignment beat.
   typedef struct packed {
      logic [47:0] ref_key;
      logic [31:0] ref_begin;
      logic [31:0] ref_end;
      logic        forward;
      logic [31:0] read_id;
      logic        flush;
   } req_type;

   // One result beat.
   typedef struct packed {
      logic [1:0]  record_kind;
      logic [31:0] first_id;
      logic [31:0] second_id;
      logic [31:0] offset_a;
      logic [31:0] offset_b;
      logic [17:0] item_count;
      logic        last;
   } rsp_type;

   // All records that one input beat produces, with a valid bit per slot.
   typedef struct packed {
      logic [SLOTS-1:0]            valid;
      rsp_type [SLOTS-1:0]         rec;
   } rec_bundle_type;

endpackage

[src/occb_cluster_engine.sv]
// Running contig and scaffold state, and the records one alignment produces.
module occb_cluster_engine
   import occb_pkg::*;
#(
   parameter int MAX_COUNT = MAX_COUNT_DEF,
   parameter int POS_BITS  = POS_BITS_DEF
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           emit_scaffolds,
   input  logic           take,
   input  req_type        req,
   output rec_bundle_type bundle
);

   localparam int CNT_W = $clog2(MAX_COUNT + 1);
   localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_COUNT);

   logic [47:0]         cur_ref_ff,   cur_ref_in;
   logic [POS_BITS-1:0] beg_ff,       beg_in;
   logic [POS_BITS-1:0] end_ff,       end_in;
   logic                open_ff,      open_in;
   logic [CNT_W-1:0]    reads_ff,     reads_in;
   logic [31:0]         contig_ff,    contig_in;
   logic [31:0]         scaffold_ff,  scaffold_in;
   logic [CNT_W-1:0]    cis_ff,       cis_in;
   logic [POS_BITS-1:0] gap_ff,       gap_in;
   logic [POS_BITS-1:0] prev_end_ff,  prev_end_in;

   logic [POS_BITS-1:0] b_pos, e_pos, beg_eff, s_off, t_off, len;
   logic                key_chg, past_end, close, scaf_close, new_open;
   logic [31:0]         contig_next, contig_place;
   logic [CNT_W-1:0]    cis_inc, reads_inc, pairs;
   logic [CNT_W+17:0]   reads_ext, pairs_ext;

   // Decode what this beat does to the open contig.
   always_comb begin
      b_pos        = POS_BITS'(req.ref_begin);
      e_pos        = POS_BITS'(req.ref_end);
      key_chg      = req.ref_key != cur_ref_ff;
      past_end     = end_ff < b_pos;
      close        = open_ff && (req.flush || key_chg || past_end);
      scaf_close   = open_ff && (req.flush || key_chg);
      new_open     = !req.flush && (!open_ff || close);
      beg_eff      = new_open ? b_pos : beg_ff;
      s_off        = b_pos - beg_eff;
      t_off        = e_pos - beg_eff;
      len          = end_ff - beg_ff;
      contig_next  = contig_ff + 32'd1;
      contig_place = close ? contig_next : contig_ff;
      cis_inc      = (cis_ff < CNT_MAX) ? cis_ff + CNT_W'(1) : cis_ff;
      reads_inc    = (reads_ff < CNT_MAX) ? reads_ff + CNT_W'(1) : reads_ff;
      pairs        = cis_inc - CNT_W'(1);
      reads_ext    = {18'b0, reads_ff};
      pairs_ext    = {18'b0, pairs};
   end

   // Build the records in output order.
   always_comb begin
      bundle = '0;

      bundle.valid[SLOT_CONTIG]                = close;
      bundle.rec[SLOT_CONTIG].record_kind      = KIND_CONTIG;
      bundle.rec[SLOT_CONTIG].first_id         = contig_ff;
      bundle.rec[SLOT_CONTIG].offset_a         = 32'(len);
      bundle.rec[SLOT_CONTIG].item_count       = reads_ext[17:0];

      bundle.valid[SLOT_PAIR]                  = close && emit_scaffolds &&
                                                 (cis_ff != '0);
      bundle.rec[SLOT_PAIR].record_kind        = KIND_PAIR;
      bundle.rec[SLOT_PAIR].first_id           = contig_ff - 32'd1;
      bundle.rec[SLOT_PAIR].second_id          = contig_ff;
      bundle.rec[SLOT_PAIR].offset_a           = 32'(gap_ff);

      bundle.valid[SLOT_SCAFFOLD]              = scaf_close && emit_scaffolds;
      bundle.rec[SLOT_SCAFFOLD].record_kind    = KIND_SCAFFOLD;
      bundle.rec[SLOT_SCAFFOLD].first_id       = scaffold_ff;
      bundle.rec[SLOT_SCAFFOLD].item_count     = pairs_ext[17:0];

      bundle.valid[SLOT_PLACEMENT]             = !req.flush;
      bundle.rec[SLOT_PLACEMENT].record_kind   = KIND_PLACEMENT;
      bundle.rec[SLOT_PLACEMENT].first_id      = req.read_id;
      bundle.rec[SLOT_PLACEMENT].second_id     = contig_place;
      bundle.rec[SLOT_PLACEMENT].offset_a      = req.forward ? 32'(s_off) : 32'(t_off);
      bundle.rec[SLOT_PLACEMENT].offset_b      = req.forward ? 32'(t_off) : 32'(s_off);
   end

   // Next state for an accepted beat.
   always_comb begin
      cur_ref_in  = cur_ref_ff;
      beg_in      = beg_ff;
      end_in      = end_ff;
      open_in     = open_ff;
      reads_in    = reads_ff;
      contig_in   = contig_ff;
      scaffold_in = scaffold_ff;
      cis_in      = cis_ff;
      gap_in      = gap_ff;
      prev_end_in = prev_end_ff;
      if (take) begin
         if (close) begin
            contig_in   = contig_next;
            prev_end_in = end_ff;
            open_in     = 1'b0;
            if (scaf_close) begin
               scaffold_in = scaffold_ff + 32'd1;
               cis_in      = '0;
            end else begin
               cis_in = cis_inc;
               gap_in = b_pos - end_ff;
            end
         end
         if (!req.flush) begin
            open_in = 1'b1;
            if (new_open) begin
               cur_ref_in = req.ref_key;
               beg_in     = b_pos;
               end_in     = e_pos;
               reads_in   = CNT_W'(1);
            end else begin
               end_in   = (end_ff < e_pos) ? e_pos : end_ff;
               reads_in = reads_inc;
            end
         end
      end
   end

   // State registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         cur_ref_ff  <= '0;
         beg_ff      <= '0;
         end_ff      <= '0;
         open_ff     <= 1'b0;
         reads_ff    <= '0;
         contig_ff   <= 32'd1;
         scaffold_ff <= 32'd1;
         cis_ff      <= '0;
         gap_ff      <= '0;
         prev_end_ff <= '0;
      end else begin
         cur_ref_ff  <= cur_ref_in;
         beg_ff      <= beg_in;
         end_ff      <= end_in;
         open_ff     <= open_in;
         reads_ff    <= reads_in;
         contig_ff   <= contig_in;
         scaffold_ff <= scaffold_in;
         cis_ff      <= cis_in;
         gap_ff      <= gap_in;
         prev_end_ff <= prev_end_in;
      end
   end

`ifndef SYNTH
   // A flush always leaves no contig open; a read always leaves one open.
   a_flush_closes: assert property (@(posedge clock) disable iff (reset)
      (take && req.flush) |=> !open_ff)
      else $error("contig still open after flush");

   a_read_opens: assert property (@(posedge clock) disable iff (reset)
      (take && !req.flush) |=> open_ff)
      else $error("no contig open after a read");

   // The contig id advances exactly when a contig closes.
   a_contig_id: assert property (@(posedge clock) disable iff (reset)
      (take && close) |=> (contig_ff == $past(contig_ff) + 32'd1))
      else $error("contig id did not advance on close");
`endif

endmodule

[src/occb_record_queue.sv]
// Holds the records of one beat and hands them out one per cycle while rsp_ready is high.
module occb_record_queue
   import occb_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  rec_bundle_type bundle,
   input  logic           req_valid,
   output logic           req_ready,
   output logic           take,
   output logic           rsp_valid,
   input  logic           rsp_ready,
   output rsp_type        rsp_data
);

   logic [SLOTS-1:0] vld_ff, vld_in;
   rsp_type [SLOTS-1:0] rec_ff, rec_in;
   logic [SLOTS-1:0] vld_rest;
   logic             pop;

   // Pending records left after the front one goes out.
   always_comb begin
      vld_rest  = vld_ff & (vld_ff - SLOTS'(1));
      rsp_valid = vld_ff != '0;
      pop       = rsp_valid && rsp_ready;
      req_ready = !rsp_valid || (rsp_ready && vld_rest == '0);
      take      = req_valid && req_ready;
   end

   // Front record is the lowest pending slot.
   always_comb begin
      rsp_data = rec_ff[SLOT_PLACEMENT];
      for (int i = SLOTS - 1; i >= 0; i--) begin
         if (vld_ff[i]) begin
            rsp_data = rec_ff[i];
         end
      end
      rsp_data.last = vld_rest == '0;
   end

   // Load a new beat's records or retire the front one.
   always_comb begin
      vld_in = vld_ff;
      rec_in = rec_ff;
      if (take) begin
         vld_in = bundle.valid;
         rec_in = bundle.rec;
      end else if (pop) begin
         vld_in = vld_rest;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
      rec_ff <= rec_in;
   end

`ifndef SYNTH
   // A beat with records shows a result in the next cycle.
   a_load_shows: assert property (@(posedge clock) disable iff (reset)
      (take && bundle.valid != '0) |=> rsp_valid)
      else $error("loaded records not presented");

   // A new beat is taken only when nothing would be left behind.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (take && rsp_valid) |-> (rsp_ready && rsp_data.last))
      else $error("records overwritten before delivery");
`endif

endmodule

[src/overlap_cluster_contig_builder.sv]
// The first result of an alignment beat is offered in the cycle after it is accepted.
// Throughput: one beat per cycle while rsp_ready is high and each beat yields one record; a
// closing beat yields up to four records, one per cycle from the queue, which sets the rate.
// Reset is synchronous and active high: no contig open, contig and scaffold ids at one,
// scaffold records enabled, queue empty.
module overlap_cluster_contig_builder
   import occb_pkg::*;
#(
   parameter int MAX_COUNT = MAX_COUNT_DEF,
   parameter int POS_BITS  = POS_BITS_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data,
   input  logic    csr_wr_en,
   input  logic    csr_wr_data
);

   logic           emit_ff, emit_in;
   logic           take;
   rec_bundle_type bundle;

   // Scaffold enable register.
   always_comb begin
      emit_in = csr_wr_en ? csr_wr_data : emit_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         emit_ff <= 1'b1;
      end else begin
         emit_ff <= emit_in;
      end
   end

   occb_cluster_engine #(
      .MAX_COUNT (MAX_COUNT),
      .POS_BITS  (POS_BITS)
   ) u_engine (
      .clock          (clock),
      .reset          (reset),
      .emit_scaffolds (emit_ff),
      .take           (take),
      .req            (req_data),
      .bundle         (bundle)
   );

   occb_record_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .bundle    (bundle),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .take      (take),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule
